### src/adam_pkg.sv
package adam_pkg;

   localparam int unsigned ParamEntriesDefault = 1024;

   localparam int unsigned IndexWidth = 10;
   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned LrWidth    = 16;
   localparam int unsigned MhatWidth  = 47;
   localparam int unsigned StepWidth  = 35;

   localparam logic [LrWidth-1:0] LrReset = 16'd66;

   // Q0.32 weights; B1 + C1 and B2 + C2 are both exactly one
   localparam logic [31:0] KB1 = 32'd3865470566;
   localparam logic [31:0] KC1 = 32'd429496730;
   localparam logic [31:0] KB2 = 32'd4290672329;
   localparam logic [31:0] KC2 = 32'd4294967;
   localparam logic [31:0] PowOne = 32'hFFFF_FFFF;

   localparam int unsigned DivSteps  = 64;
   localparam int unsigned SqrtSteps = 32;

   typedef enum logic [CmdWidth-1:0] {
      CMD_UPDATE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] moment1;
      logic [63:0] moment2;
      logic [31:0] power1;
      logic [31:0] power2;
   } entry_type;

   // add half an lsb of a Q32 product, then drop the fraction
   function automatic logic [33:0] rnd_q32(input logic [65:0] x);
      logic [65:0] s;
      s = x + 66'h0_8000_0000;
      return s[65:32];
   endfunction

endpackage

### src/adam_parameter_update_core.sv
// Adam update engine over a table of scalar parameters held in one on-chip
// memory. Commands are taken with start while busy is low and each one gives
// exactly one result strobe on rsp_valid, which the receiver must take at once.
// After reset the block sweeps the table to its reset contents, one entry per
// cycle, and holds busy high until the sweep is done. Clear, load, unused
// commands and out-of-range indexes pass through the read state and strobe
// their result from a register. An update runs the read state, the steps of
// shared 33x33 multiplier work, three radix-2 divisions, two square roots and
// the steps that form the rate product, write back and strobe, all run one
// after another on one divider and one root unit. A new command can be
// taken at the end of the strobe cycle. The learning rate register may be
// written only while busy is low.
module adam_parameter_update_core #(
   parameter int unsigned PARAM_ENTRIES = adam_pkg::ParamEntriesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [adam_pkg::CmdWidth-1:0]       req_cmd,
   input  logic [adam_pkg::IndexWidth-1:0]     req_entry_index,
   input  logic signed [adam_pkg::DataWidth-1:0] req_gradient,
   input  logic signed [adam_pkg::DataWidth-1:0] req_load_value,
   output logic                                rsp_valid,
   output logic signed [adam_pkg::DataWidth-1:0] rsp_param_out,
   output logic [adam_pkg::IndexWidth-1:0]     rsp_index_out,
   input  logic                                csr_wr_en,
   input  logic [adam_pkg::LrWidth-1:0]        csr_wr_data
);
   import adam_pkg::*;

   localparam int unsigned AddrWidth = (PARAM_ENTRIES > 1) ? $clog2(PARAM_ENTRIES) : 1;
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(PARAM_ENTRIES - 1);
   localparam logic [5:0] DivLast  = 6'(DivSteps - 1);
   localparam logic [5:0] SqrtLast = 6'(SqrtSteps - 1);
   localparam logic signed [65:0] HalfLsb = 66'sh0_8000_0000;
   localparam logic signed [35:0] ValMax = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] ValMin = -36'sh0_8000_0000;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_P1, ST_P2, ST_MA, ST_MB, ST_VA, ST_VB,
      ST_VC, ST_VD, ST_VE, ST_VF, ST_DIV1, ST_SQV, ST_SQB, ST_DIV2, ST_LR,
      ST_DIV3, ST_APPLY
   } state_type;

   entry_type mem [PARAM_ENTRIES];
   entry_type rd_data_ff;
   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr;
   entry_type            wr_data;

   state_type state_ff;
   logic [AddrWidth-1:0] clr_cnt_ff;
   logic [LrWidth-1:0] lr_ff;
   cmd_type cmd_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic in_range_ff;
   logic signed [31:0] grad_ff;
   logic [31:0] load_ff;
   entry_type ent_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in;
   logic [33:0] prod_rnd;
   logic signed [65:0] acc_ff, acc_rnd;
   logic [63:0] vacc_ff, gsq_ff;
   logic [31:0] p1_ff, p2_ff, mn_ff;
   logic [MhatWidth-1:0] mhat_ff;
   logic [32:0] sqv_ff;
   logic [31:0] gmag, mmag;
   logic [32:0] bias1, bias2;

   logic [63:0] dvd_ff, dvs_ff, dvd_nx;
   logic [64:0] rem_ff, rem_sh, rem_nx;
   logic div_ge;
   logic [63:0] sq_x_ff;
   logic [35:0] sq_rem_ff, sq_rem_sh, sq_trial, sq_rem_nx;
   logic [33:0] sq_root_ff, sq_root_nx;
   logic sq_ge;
   logic [5:0] cnt_ff;

   logic [16:0] sb2;
   logic [StepWidth-1:0] step;
   logic signed [35:0] val_sum, val_sat;

   logic rsp_valid_ff;
   logic [31:0] rsp_param_ff;
   logic [IndexWidth-1:0] rsp_index_ff;

   logic accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[AddrWidth'(req_entry_index)];
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_P1: begin mul_a = {1'b0, ent_ff.power1}; mul_b = {1'b0, KB1}; end
         ST_P2: begin mul_a = {1'b0, ent_ff.power2}; mul_b = {1'b0, KB2}; end
         ST_MA: begin mul_a = {ent_ff.moment1[31], ent_ff.moment1}; mul_b = {1'b0, KB1}; end
         ST_MB: begin mul_a = {grad_ff[31], grad_ff}; mul_b = {1'b0, KC1}; end
         ST_VA: begin mul_a = {1'b0, ent_ff.moment2[63:32]}; mul_b = {1'b0, KB2}; end
         ST_VB: begin mul_a = {1'b0, ent_ff.moment2[31:0]}; mul_b = {1'b0, KB2}; end
         ST_VC: begin mul_a = {1'b0, gmag}; mul_b = {1'b0, gmag}; end
         ST_VD: begin mul_a = {1'b0, prod_ff[63:32]}; mul_b = {1'b0, KC2}; end
         ST_VE: begin mul_a = {1'b0, gsq_ff[31:0]}; mul_b = {1'b0, KC2}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = rnd_q32(prod_ff);

   assign gmag    = grad_ff[31] ? 32'(-grad_ff) : grad_ff;
   assign mmag    = mn_ff[31] ? 32'(-mn_ff) : mn_ff;
   assign bias1   = 33'h1_0000_0000 - {1'b0, p1_ff};
   assign bias2   = 33'h1_0000_0000 - {1'b0, p2_ff};
   assign acc_rnd = acc_ff + HalfLsb;

   // radix-2 restoring divider, quotient shifts into the dividend register
   assign rem_sh = {rem_ff[63:0], dvd_ff[63]};
   assign div_ge = (rem_sh >= {1'b0, dvs_ff});
   assign rem_nx = div_ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
   assign dvd_nx = {dvd_ff[62:0], div_ge};

   // digit-by-digit square root, two radicand bits per step
   assign sq_rem_sh  = {sq_rem_ff[33:0], sq_x_ff[63:62]};
   assign sq_trial   = {sq_root_ff, 2'b01};
   assign sq_ge      = (sq_rem_sh >= sq_trial);
   assign sq_rem_nx  = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
   assign sq_root_nx = {sq_root_ff[32:0], sq_ge};

   assign sb2  = (sq_root_nx[16:0] == 17'd0) ? 17'd1 : sq_root_nx[16:0];
   assign step = (dvd_ff > 64'h4_0000_0000) ? StepWidth'(35'h4_0000_0000)
                                            : dvd_ff[StepWidth-1:0];

   assign val_sum = mn_ff[31] ? (36'(signed'(ent_ff.value)) + signed'({1'b0, step}))
                              : (36'(signed'(ent_ff.value)) - signed'({1'b0, step}));
   assign val_sat = (val_sum > ValMax) ? ValMax : ((val_sum < ValMin) ? ValMin : val_sum);

   // write-back port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AddrWidth'(idx_ff);
      wr_data = rd_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '{value: '0, moment1: '0, moment2: '0, power1: PowOne, power2: PowOne};
         end
         ST_READ: begin
            if (in_range_ff && cmd_ff == CMD_CLEAR) begin
               wr_en = 1'b1;
               wr_data.moment1 = '0;
               wr_data.moment2 = '0;
               wr_data.power1  = PowOne;
               wr_data.power2  = PowOne;
            end else if (in_range_ff && cmd_ff == CMD_LOAD) begin
               wr_en = 1'b1;
               wr_data.value = load_ff;
            end
         end
         ST_APPLY: begin
            wr_en   = 1'b1;
            wr_data = '{value: val_sat[31:0], moment1: mn_ff, moment2: vacc_ff,
                        power1: p1_ff, power2: p2_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         lr_ff        <= LrReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         // strobe after a short command or after the write-back of an update
         rsp_valid_ff <= (state_ff == ST_APPLY) ||
                         (state_ff == ST_READ && !(in_range_ff && cmd_ff == CMD_UPDATE));
         if (csr_wr_en) begin
            lr_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LastAddr) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff      <= cmd_type'(req_cmd);
                  idx_ff      <= req_entry_index;
                  in_range_ff <= (32'(req_entry_index) < 32'(PARAM_ENTRIES));
                  grad_ff     <= req_gradient;
                  load_ff     <= req_load_value;
                  state_ff    <= ST_READ;
               end
            end
            ST_READ: begin
               ent_ff        <= rd_data_ff;
               rsp_index_ff  <= idx_ff;
               if (in_range_ff && cmd_ff == CMD_UPDATE) begin
                  state_ff <= ST_P1;
               end else begin
                  state_ff     <= ST_IDLE;
                  if (!in_range_ff) begin
                     rsp_param_ff <= '0;
                  end else if (cmd_ff == CMD_LOAD) begin
                     rsp_param_ff <= load_ff;
                  end else begin
                     rsp_param_ff <= rd_data_ff.value;
                  end
               end
            end
            ST_P1: state_ff <= ST_P2;
            ST_P2: begin
               p1_ff    <= prod_rnd[31:0];
               state_ff <= ST_MA;
            end
            ST_MA: begin
               p2_ff    <= prod_rnd[31:0];
               state_ff <= ST_MB;
            end
            ST_MB: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_VA;
            end
            ST_VA: begin
               acc_ff   <= acc_ff + prod_ff;
               state_ff <= ST_VB;
            end
            ST_VB: begin
               vacc_ff  <= prod_ff[63:0];
               mn_ff    <= acc_rnd[63:32];
               state_ff <= ST_VC;
            end
            ST_VC: begin
               vacc_ff  <= vacc_ff + 64'(prod_rnd);
               state_ff <= ST_VD;
            end
            ST_VD: begin
               gsq_ff   <= prod_ff[63:0];
               state_ff <= ST_VE;
            end
            ST_VE: begin
               vacc_ff  <= vacc_ff + prod_ff[63:0];
               state_ff <= ST_VF;
            end
            ST_VF: begin
               vacc_ff  <= vacc_ff + 64'(prod_rnd);
               dvd_ff   <= {mmag, 32'd0};
               dvs_ff   <= 64'(bias1);
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV1;
            end
            ST_DIV1: begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               if (cnt_ff == DivLast) begin
                  // limit the corrected moment to 47 bits
                  mhat_ff    <= (dvd_nx[63:MhatWidth] != '0) ? '1 : dvd_nx[MhatWidth-1:0];
                  sq_x_ff    <= vacc_ff;
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_SQV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQV: begin
               if (cnt_ff == SqrtLast) begin
                  sqv_ff     <= sq_root_nx[32:0];
                  sq_x_ff    <= 64'(bias2);
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_SQB;
               end else begin
                  sq_x_ff    <= {sq_x_ff[61:0], 2'b00};
                  sq_rem_ff  <= sq_rem_nx;
                  sq_root_ff <= sq_root_nx;
                  cnt_ff     <= cnt_ff + 1'b1;
               end
            end
            ST_SQB: begin
               sq_x_ff    <= {sq_x_ff[61:0], 2'b00};
               sq_rem_ff  <= sq_rem_nx;
               sq_root_ff <= sq_root_nx;
               if (cnt_ff == SqrtLast) begin
                  dvd_ff   <= {15'd0, sqv_ff, 16'd0};
                  dvs_ff   <= 64'(sb2);
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV2;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV2: begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DivLast) begin
                  // epsilon of one lsb on the denominator
                  dvs_ff   <= dvd_nx + 64'd1;
                  state_ff <= ST_LR;
               end
            end
            ST_LR: begin
               dvd_ff   <= {1'b0, {47'd0, lr_ff} * {16'd0, mhat_ff}};
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV3;
            end
            ST_DIV3: begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DivLast) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               rsp_param_ff <= val_sat[31:0];
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // the step is held in the divider's quotient while the value is applied
   always_comb begin
      rsp_valid     = rsp_valid_ff;
      rsp_param_out = signed'(rsp_param_ff);
      rsp_index_out = rsp_index_ff;
   end

   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transaction accepted but block not busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result strobes in a row");

endmodule
